@@ rtl/eiphp_pkg.sv @@
// ----------------------------------------------------------------------------
// eiphp_pkg
// Types and constants for the Ethernet / IPv4 header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package eiphp_pkg;

   localparam int unsigned HEADER_BYTES = 96;

   localparam logic [15:0] MAX_FRAME_RESET = 16'd1600;
   localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
   localparam logic [7:0]  PROTO_TCP       = 8'd6;
   localparam logic [7:0]  PROTO_UDP       = 8'd17;

   localparam logic [6:0]  ETH_HDR_BYTES   = 7'd14;
   localparam logic [6:0]  IP_MIN_END      = 7'd34;
   localparam logic [6:0]  TCP_HDR_BYTES   = 7'd20;
   localparam logic [6:0]  UDP_HDR_BYTES   = 7'd8;

   // fixed byte positions in the frame
   localparam logic [15:0] POS_ETYPE_HI = 16'd12;
   localparam logic [15:0] POS_ETYPE_LO = 16'd13;
   localparam logic [15:0] POS_VER_IHL  = 16'd14;
   localparam logic [15:0] POS_TLEN_HI  = 16'd16;
   localparam logic [15:0] POS_TLEN_LO  = 16'd17;
   localparam logic [15:0] POS_IDENT_HI = 16'd18;
   localparam logic [15:0] POS_IDENT_LO = 16'd19;
   localparam logic [15:0] POS_TTL      = 16'd22;
   localparam logic [15:0] POS_PROTO    = 16'd23;
   localparam logic [15:0] POS_SRC_0    = 16'd26;
   localparam logic [15:0] POS_SRC_1    = 16'd27;
   localparam logic [15:0] POS_SRC_2    = 16'd28;
   localparam logic [15:0] POS_SRC_3    = 16'd29;
   localparam logic [15:0] POS_DST_0    = 16'd30;
   localparam logic [15:0] POS_DST_1    = 16'd31;
   localparam logic [15:0] POS_DST_2    = 16'd32;
   localparam logic [15:0] POS_DST_3    = 16'd33;

   // byte offsets from the start of the transport header
   localparam logic [15:0] TP_SPORT_HI = 16'd0;
   localparam logic [15:0] TP_SPORT_LO = 16'd1;
   localparam logic [15:0] TP_DPORT_HI = 16'd2;
   localparam logic [15:0] TP_DPORT_LO = 16'd3;
   localparam logic [15:0] TP_DOFF     = 16'd12;

   typedef enum logic [2:0] {
      ST_SHORT     = 3'd0,
      ST_NON_IP    = 3'd1,
      ST_IP_NO_HDR = 3'd2,
      ST_IP_ONLY   = 3'd3,
      ST_TCP       = 3'd4,
      ST_UDP       = 3'd5,
      ST_OVERSIZE  = 3'd6
   } frame_status_type;

   typedef struct packed {
      logic [7:0]         ip_time_to_live;
      logic [15:0]        ip_ident;
      logic [15:0]        destination_port;
      logic [15:0]        source_port;
      logic [31:0]        destination_address;
      logic [31:0]        source_address;
      logic signed [16:0] payload_length;
      logic [5:0]         transport_header_bytes;
      logic [5:0]         ip_header_bytes;
      logic [15:0]        ip_total_length;
      logic [7:0]         ip_protocol;
      frame_status_type   frame_status;
   } record_type;

endpackage

`default_nettype wire

@@ rtl/ethernet_ipv4_header_parser.sv @@
// ----------------------------------------------------------------------------
// ethernet_ipv4_header_parser
// Counts frame bytes, captures the Ethernet/IPv4/TCP/UDP header fields as
// they stream by and emits one classified record per frame.
// ----------------------------------------------------------------------------
//  channel  dir  tdata/data                          tlast      tuser
//  req_     in   [7:0] data_byte                     last_byte  -
//  rsp_     out  176-bit record (see port comment)   -          -
//  csr_     in   [15:0] max_frame_bytes              -          -
//
//  One byte is accepted per cycle. Accepting the last byte captures the
//  frame length and marks the frame pending; the classified record is
//  loaded into the output register once that register is free.
//  Input stalls only while a finished frame waits for the classify stage
//  and the output register is still held by rsp_tready low.
//  Reset is synchronous; max_frame_bytes returns to 1600.
// ----------------------------------------------------------------------------
`default_nettype none

module ethernet_ipv4_header_parser
   import eiphp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,

   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,    // [7:0] data_byte
   input  wire logic         req_tlast,    // last_byte

   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [2:0] frame_status, [10:3] ip_protocol, [26:11] ip_total_length,
   // [32:27] ip_header_bytes, [38:33] transport_header_bytes,
   // [55:39] payload_length, [87:56] source_address,
   // [119:88] destination_address, [135:120] source_port,
   // [151:136] destination_port, [167:152] ip_ident, [175:168] ip_time_to_live
   output logic [175:0]      rsp_tdata,

   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [15:0]  csr_data     // max_frame_bytes
);

   logic [15:0] max_ff;
   logic [15:0] count_ff, count_in;
   logic        pend_ff, pend_in;
   logic [15:0] len_ff, len_in;
   logic        rsp_valid_ff, rsp_valid_in;
   record_type  rec_ff, rec_in;

   // captured header fields
   logic [15:0] etype_ff;
   logic [3:0]  ihl_ff;
   logic [15:0] tlen_ff;
   logic [15:0] ident_ff;
   logic [7:0]  ttl_ff;
   logic [7:0]  proto_ff;
   logic [31:0] src_ff;
   logic [31:0] dst_ff;
   logic [15:0] sport_ff;
   logic [15:0] dport_ff;
   logic [3:0]  doff_ff;

   logic        req_fire;
   logic        advance;
   logic [15:0] count_sat;
   logic [3:0]  ihl_cur;
   logic [6:0]  tp_base;
   logic [15:0] tp_off;

   assign csr_ready  = 1'b1;
   assign advance    = pend_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !pend_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign count_sat = (count_ff == 16'hFFFF) ? count_ff : count_ff + 16'd1;
   // the IHL byte may be the one arriving right now
   assign ihl_cur   = (count_ff == POS_VER_IHL) ? req_tdata[3:0] : ihl_ff;
   assign tp_base   = ETH_HDR_BYTES + {1'b0, ihl_cur, 2'b00};
   assign tp_off    = count_ff - {9'd0, tp_base};

   // ---------------- capture stage ----------------
   always_comb begin
      count_in = count_ff;
      pend_in  = pend_ff && !advance;
      len_in   = len_ff;
      if (req_fire) begin
         count_in = req_tlast ? 16'd0 : count_sat;
         if (req_tlast) begin
            pend_in = 1'b1;
            len_in  = count_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
         max_ff   <= MAX_FRAME_RESET;
      end else begin
         count_ff <= count_in;
         pend_ff  <= pend_in;
         if (csr_valid && csr_ready) begin
            max_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
      if (req_fire) begin
         case (count_ff)
            POS_ETYPE_HI: etype_ff[15:8] <= req_tdata;
            POS_ETYPE_LO: etype_ff[7:0]  <= req_tdata;
            POS_VER_IHL:  ihl_ff         <= req_tdata[3:0];
            POS_TLEN_HI:  tlen_ff[15:8]  <= req_tdata;
            POS_TLEN_LO:  tlen_ff[7:0]   <= req_tdata;
            POS_IDENT_HI: ident_ff[15:8] <= req_tdata;
            POS_IDENT_LO: ident_ff[7:0]  <= req_tdata;
            POS_TTL:      ttl_ff         <= req_tdata;
            POS_PROTO:    proto_ff       <= req_tdata;
            POS_SRC_0:    src_ff[31:24]  <= req_tdata;
            POS_SRC_1:    src_ff[23:16]  <= req_tdata;
            POS_SRC_2:    src_ff[15:8]   <= req_tdata;
            POS_SRC_3:    src_ff[7:0]    <= req_tdata;
            POS_DST_0:    dst_ff[31:24]  <= req_tdata;
            POS_DST_1:    dst_ff[23:16]  <= req_tdata;
            POS_DST_2:    dst_ff[15:8]   <= req_tdata;
            POS_DST_3:    dst_ff[7:0]    <= req_tdata;
            default: ;
         endcase
         // transport header sits at a frame-dependent offset
         case (tp_off)
            TP_SPORT_HI: sport_ff[15:8] <= req_tdata;
            TP_SPORT_LO: sport_ff[7:0]  <= req_tdata;
            TP_DPORT_HI: dport_ff[15:8] <= req_tdata;
            TP_DPORT_LO: dport_ff[7:0]  <= req_tdata;
            TP_DOFF:     doff_ff        <= req_tdata[7:4];
            default: ;
         endcase
      end
   end

   // ---------------- classify stage ----------------
   logic [16:0] len_x;
   logic [16:0] up_to_ip;
   logic [5:0]  ihl_bytes;
   logic [5:0]  thl;

   assign len_x     = {1'b0, len_ff};
   assign ihl_bytes = {ihl_ff, 2'b00};
   assign up_to_ip  = {10'd0, ETH_HDR_BYTES} + {11'd0, ihl_bytes};

   always_comb begin
      rec_in       = '0;
      rec_in.frame_status = ST_SHORT;
      thl          = '0;
      if (len_ff > max_ff) begin
         rec_in.frame_status = ST_OVERSIZE;
      end else if (len_ff < {9'd0, ETH_HDR_BYTES}) begin
         rec_in.frame_status = ST_SHORT;
      end else if (etype_ff != ETHERTYPE_IPV4) begin
         rec_in.frame_status = ST_NON_IP;
      end else if (len_ff < {9'd0, IP_MIN_END}) begin
         rec_in.frame_status = ST_IP_NO_HDR;
      end else begin
         rec_in.frame_status        = ST_IP_ONLY;
         rec_in.ip_protocol         = proto_ff;
         rec_in.ip_total_length     = tlen_ff;
         rec_in.ip_header_bytes     = ihl_bytes;
         rec_in.source_address      = src_ff;
         rec_in.destination_address = dst_ff;
         rec_in.ip_ident            = ident_ff;
         rec_in.ip_time_to_live     = ttl_ff;
         if (up_to_ip != len_x) begin
            if (proto_ff == PROTO_TCP &&
                len_x >= up_to_ip + {10'd0, TCP_HDR_BYTES}) begin
               rec_in.frame_status = ST_TCP;
               thl = {doff_ff, 2'b00};
            end else if (proto_ff == PROTO_UDP &&
                         len_x >= up_to_ip + {10'd0, UDP_HDR_BYTES}) begin
               rec_in.frame_status = ST_UDP;
               thl = UDP_HDR_BYTES[5:0];
            end
            if (rec_in.frame_status == ST_TCP || rec_in.frame_status == ST_UDP) begin
               rec_in.transport_header_bytes = thl;
               rec_in.payload_length = $signed({1'b0, tlen_ff} - {11'd0, thl}
                                               - {11'd0, ihl_bytes});
               rec_in.source_port      = sport_ff;
               rec_in.destination_port = dport_ff;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rec_ff <= rec_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rec_ff;

   // ---------------- assertions ----------------
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      pend_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("input accepted while a finished frame is blocked");

   a_count_clear: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tlast |=> count_ff == 16'd0)
      else $error("byte count not cleared after last byte");

   a_oversize_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rec_ff.frame_status == ST_OVERSIZE |->
         rec_ff.ip_protocol == 8'd0 && rec_ff.source_address == 32'd0 &&
         rec_ff.source_port == 16'd0 && rec_ff.payload_length == 17'sd0)
      else $error("oversize record carries field data");

   a_udp_hdr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rec_ff.frame_status == ST_UDP |->
         rec_ff.transport_header_bytes == UDP_HDR_BYTES[5:0])
      else $error("UDP record with wrong transport header length");

   a_pend_to_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("record lost between classify and output register");

endmodule

`default_nettype wire

@@ sim/eiphp_checker.sv @@
// ----------------------------------------------------------------------------
// eiphp_checker
// Watches the byte, record and register channels of the header parser. Keeps
// its own copy of the header bytes, byte count and frame limit, predicts the
// record for every frame end and compares each returned record field by field.
// ----------------------------------------------------------------------------
module eiphp_checker
   import eiphp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  logic         req_tlast,

   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [175:0] rsp_tdata,

   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [15:0]  csr_data,

   output int           error_count,
   output int           records_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [7:0]  frame_bytes [HEADER_BYTES];
   logic [15:0] byte_count;
   logic [15:0] max_frame;
   record_type  expected_records [$];
   record_type  want;

   function automatic logic [7:0] byte_at(input int idx);
      return (idx < HEADER_BYTES) ? frame_bytes[idx] : 8'h00;
   endfunction

   function automatic logic [15:0] word_at(input int idx);
      return {byte_at(idx), byte_at(idx + 1)};
   endfunction

   function automatic record_type classify_frame(input logic [15:0] len);
      record_type  rec;
      logic [7:0]  ver_ihl;
      logic [7:0]  doff;
      logic [5:0]  ihl;
      logic [5:0]  thl;
      logic [15:0] tp;
      logic [31:0] diff;
      rec = '0;
      rec.frame_status = ST_SHORT;
      if (len > max_frame) begin
         rec.frame_status = ST_OVERSIZE;
         return rec;
      end
      if (len < ETH_HDR_BYTES)
         return rec;
      if (word_at(POS_ETYPE_HI) != ETHERTYPE_IPV4) begin
         rec.frame_status = ST_NON_IP;
         return rec;
      end
      if (len < IP_MIN_END) begin
         rec.frame_status = ST_IP_NO_HDR;
         return rec;
      end
      ver_ihl = byte_at(POS_VER_IHL);
      ihl = {ver_ihl[3:0], 2'b00};
      rec.frame_status        = ST_IP_ONLY;
      rec.ip_protocol         = byte_at(POS_PROTO);
      rec.ip_total_length     = word_at(POS_TLEN_HI);
      rec.ip_header_bytes     = ihl;
      rec.source_address      = {word_at(POS_SRC_0), word_at(POS_SRC_2)};
      rec.destination_address = {word_at(POS_DST_0), word_at(POS_DST_2)};
      rec.ip_ident            = word_at(POS_IDENT_HI);
      rec.ip_time_to_live     = byte_at(POS_TTL);
      tp = ETH_HDR_BYTES + ihl;
      // header ending exactly at frame end leaves no room for transport
      if (tp == len)
         return rec;
      if (rec.ip_protocol == PROTO_TCP && len >= tp + TCP_HDR_BYTES) begin
         rec.frame_status = ST_TCP;
         doff = byte_at(tp + TP_DOFF);
         thl = {doff[7:4], 2'b00};
      end else if (rec.ip_protocol == PROTO_UDP && len >= tp + UDP_HDR_BYTES) begin
         rec.frame_status = ST_UDP;
         thl = 6'(UDP_HDR_BYTES);
      end else begin
         return rec;
      end
      rec.transport_header_bytes = thl;
      diff = {16'h0, rec.ip_total_length} - {26'h0, thl} - {26'h0, ihl};
      rec.payload_length   = diff[16:0];
      rec.source_port      = word_at(tp + TP_SPORT_HI);
      rec.destination_port = word_at(tp + TP_DPORT_HI);
      return rec;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s expected %0h got %0h", $realtime, name, exp_val, act_val);
         error_count++;
      end
   endtask

   task automatic compare_record(input record_type exp_rec, input record_type act_rec);
      check_field("frame_status", 32'(exp_rec.frame_status), 32'(act_rec.frame_status));
      check_field("ip_protocol", 32'(exp_rec.ip_protocol), 32'(act_rec.ip_protocol));
      check_field("ip_total_length", 32'(exp_rec.ip_total_length),
                  32'(act_rec.ip_total_length));
      check_field("ip_header_bytes", 32'(exp_rec.ip_header_bytes),
                  32'(act_rec.ip_header_bytes));
      check_field("transport_header_bytes", 32'(exp_rec.transport_header_bytes),
                  32'(act_rec.transport_header_bytes));
      check_field("payload_length", 32'(exp_rec.payload_length),
                  32'(act_rec.payload_length));
      check_field("source_address", exp_rec.source_address, act_rec.source_address);
      check_field("destination_address", exp_rec.destination_address,
                  act_rec.destination_address);
      check_field("source_port", 32'(exp_rec.source_port), 32'(act_rec.source_port));
      check_field("destination_port", 32'(exp_rec.destination_port),
                  32'(act_rec.destination_port));
      check_field("ip_ident", 32'(exp_rec.ip_ident), 32'(act_rec.ip_ident));
      check_field("ip_time_to_live", 32'(exp_rec.ip_time_to_live),
                  32'(act_rec.ip_time_to_live));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         byte_count = '0;
         max_frame = MAX_FRAME_RESET;
         expected_records.delete();
      end else begin
         if (csr_valid && csr_ready)
            max_frame = csr_data;
         if (req_tvalid && req_tready) begin
            if (byte_count < HEADER_BYTES)
               frame_bytes[byte_count] = req_tdata;
            if (byte_count != 16'hFFFF)
               byte_count = byte_count + 16'd1;
            if (req_tlast) begin
               expected_records.push_back(classify_frame(byte_count));
               byte_count = '0;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_records.size() == 0) begin
               $display("%0t: record expected none got %0h", $realtime, rsp_tdata);
               error_count++;
            end else begin
               want = expected_records.pop_front();
               compare_record(want, record_type'(rsp_tdata));
            end
         end
      end
      records_pending <= expected_records.size();
   end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Feeds Ethernet frames byte by byte into the header parser: directed frames
// for every status and corner, then random frames under several frame limits,
// with bursty input and a stalling receiver. The checker predicts the records.
// ----------------------------------------------------------------------------
module tb_top;
   import eiphp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200_000;
   localparam int SETTLE_CYCLES = 8;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [175:0] rsp_tdata;
   logic         csr_valid;
   logic         csr_ready;
   logic [15:0]  csr_data;

   int           mismatches;
   int           records_pending;
   int           cycles;
   int           burst_left;
   int           ready_hold;
   int           phase_bytes;
   int           phase_frames;
   logic [7:0]   frame_buf [$];

   ethernet_ipv4_header_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   eiphp_checker parse_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .error_count     (mismatches),
      .records_pending (records_pending)
   );

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
   end

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // receiver: long ready stretches with stalls of random length in between
   always @(posedge clock) begin
      if (ready_hold == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b1;
            ready_hold <= $urandom_range(0, 40);
         end else begin
            rsp_tready <= 1'b0;
            ready_hold <= $urandom_range(0, 12);
         end
      end else begin
         ready_hold <= ready_hold - 1;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_frame();
      int k;
      for (k = 0; k < frame_buf.size(); k++)
         send_byte(frame_buf[k], k == frame_buf.size() - 1);
      phase_bytes += frame_buf.size();
      phase_frames++;
   endtask

   function automatic void place(input int pos, input logic [7:0] v);
      if (pos < frame_buf.size())
         frame_buf[pos] = v;
   endfunction

   // fill < 0 gives random filler bytes, else every filler byte is fill
   function automatic void compose_frame(input int len, input logic [15:0] etype,
                                         input logic [7:0] ver_ihl,
                                         input logic [7:0] proto,
                                         input logic [7:0] doff,
                                         input logic [15:0] tot_len, input int fill);
      int k;
      int tp;
      frame_buf.delete();
      for (k = 0; k < len; k++)
         frame_buf.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
      tp = 14 + 4 * ver_ihl[3:0];
      place(POS_ETYPE_HI, etype[15:8]);
      place(POS_ETYPE_LO, etype[7:0]);
      place(POS_VER_IHL, ver_ihl);
      place(POS_TLEN_HI, tot_len[15:8]);
      place(POS_TLEN_LO, tot_len[7:0]);
      place(POS_PROTO, proto);
      place(tp + TP_DOFF, doff);
   endfunction

   task automatic random_frame();
      int roll;
      int ihl;
      int tp;
      int len;
      logic [7:0]  ver_ihl;
      logic [7:0]  proto;
      logic [7:0]  doff;
      logic [15:0] etype;
      logic [15:0] tot;
      roll = $urandom_range(0, 99);
      ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
      ver_ihl = {($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'h4, 4'(ihl)};
      tp = 14 + 4 * ihl;
      etype = ETHERTYPE_IPV4;
      doff = {4'($urandom_range(5, 15)), 4'($urandom)};
      if ($urandom_range(0, 5) == 0)
         doff = 8'($urandom);
      proto = 8'($urandom);
      if (roll < 15) begin
         // junk or truncated frames, ethertype often not IPv4
         if ($urandom_range(0, 1) == 0)
            etype = 16'($urandom);
         len = $urandom_range(1, 40);
      end else if (roll < 30) begin
         len = $urandom_range(14, tp + 30);
      end else begin
         proto = (roll < 65) ? PROTO_TCP : PROTO_UDP;
         len = tp + $urandom_range(0, 64) - 4;
      end
      tot = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'(len - 14);
      compose_frame(len, etype, ver_ihl, proto, doff, tot, -1);
      send_frame();
   endtask

   // let all records drain and the pipeline empty out
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (records_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_frame(input logic [15:0] v);
      settle();
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(input logic [15:0] limit);
      write_max_frame(limit);
      phase_bytes = 0;
      phase_frames = 0;
      while (phase_bytes < 40 || phase_frames < 2)
         random_frame();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // short frames, non-IP, IPv4 without full header
      compose_frame(1, 16'h0, 8'h0, 8'h0, 8'h0, 16'h0, 8'h00);
      send_frame();
      compose_frame(13, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
      send_frame();
      compose_frame(14, 16'h86DD, 8'h45, PROTO_TCP, 8'h50, 16'd40, -1);
      send_frame();
      compose_frame(14, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'h50, 16'd40, -1);
      send_frame();
      compose_frame(33, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'h50, 16'd40, -1);
      send_frame();
      // IP header ends exactly at frame end
      compose_frame(34, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'h50, 16'd20, -1);
      send_frame();
      // full TCP / UDP and each cut one byte short
      compose_frame(54, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'h50, 16'd40, -1);
      send_frame();
      compose_frame(53, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'h50, 16'd40, -1);
      send_frame();
      compose_frame(42, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 8'h00, 16'd28, -1);
      send_frame();
      compose_frame(41, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 8'h00, 16'd28, -1);
      send_frame();
      // other protocol
      compose_frame(40, ETHERTYPE_IPV4, 8'h45, 8'd1, 8'h50, 16'd26, -1);
      send_frame();
      // header length nibble zero: transport starts right after Ethernet
      compose_frame(34, ETHERTYPE_IPV4, 8'h40, PROTO_TCP, 8'hA0, 16'd20, -1);
      send_frame();
      // largest headers, zero total length, frame runs past the store
      compose_frame(98, ETHERTYPE_IPV4, 8'h4F, PROTO_TCP, 8'hF0, 16'd0, -1);
      send_frame();
      compose_frame(100, ETHERTYPE_IPV4, 8'hFF, PROTO_UDP, 8'hFF, 16'hFFFF, 8'hFF);
      send_frame();
      compose_frame(40, ETHERTYPE_IPV4, 8'h00, PROTO_UDP, 8'h00, 16'h0000, 8'h00);
      send_frame();
      // frame limit: exactly at and one past
      write_max_frame(16'd42);
      compose_frame(42, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 8'h00, 16'd28, -1);
      send_frame();
      compose_frame(43, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 8'h00, 16'd29, -1);
      send_frame();
      // limit zero: every frame oversize
      write_max_frame(16'd0);
      compose_frame(1, 16'h0, 8'h0, 8'h0, 8'h0, 16'h0, 8'h00);
      send_frame();
      compose_frame(20, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 8'h50, 16'd40, -1);
      send_frame();

      random_phase(MAX_FRAME_RESET);
      random_phase(16'($urandom_range(20, 90)));
      random_phase(16'hFFFF);

      settle();
      if (mismatches == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
